// ----- hdl/scsa_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and config helpers of the size-class slot allocator
// no dependencies

package scsa_pkg;

  localparam int NUM_CLASSES    = 4;
  localparam int CLS_W          = $clog2(NUM_CLASSES);
  localparam int MAX_SLOTS_LOG2 = 8;
  localparam int SLOT_W         = MAX_SLOTS_LOG2;
  localparam int ADDR_W         = CLS_W + SLOT_W;
  localparam int CNT_W          = MAX_SLOTS_LOG2 + 1;
  localparam int SIZE_W         = 20;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;

  localparam logic [4:0] MIN_BLOCK_LOG2 = 5'd4;
  localparam logic [4:0] MAX_BLOCK_LOG2 = 5'd16;
  localparam logic [3:0] MIN_BASE_LOG2  = 4'd3;
  localparam logic [3:0] MAX_BASE_LOG2  = 4'(MAX_SLOTS_LOG2);
  localparam logic [2:0] MIN_CLASSES    = 3'd2;
  localparam logic [2:0] MAX_CLASSES    = 3'(NUM_CLASSES);

  localparam logic [4:0] RST_MIN_LOG2  = 5'd4;
  localparam logic [2:0] RST_CLASSES   = 3'd4;
  localparam logic [3:0] RST_BASE_LOG2 = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOG2 = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_SIZE,
    ST_EXHAUSTED,
    ST_BAD_HANDLE,
    ST_DOUBLE_FREE
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] req_size;
    logic [1:0]        free_class;
    logic [7:0]        free_slot;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [1:0] grant_class;
    logic [7:0] grant_slot;
    logic [8:0] free_left;
  } out_item_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [4:0] min_log2;
    logic [2:0] classes;
    logic [3:0] base_log2;
  } cfg_t;

  // classified request between front and back
  typedef struct packed {
    logic              op;
    status_t           err;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } req_t;

  function automatic cfg_t eff_cfg(logic [4:0] raw_min, logic [2:0] raw_cls,
                                   logic [3:0] raw_base);
    cfg_t c;
    c.min_log2 = raw_min;
    if (raw_min < MIN_BLOCK_LOG2) c.min_log2 = MIN_BLOCK_LOG2;
    if (raw_min > MAX_BLOCK_LOG2) c.min_log2 = MAX_BLOCK_LOG2;
    c.base_log2 = raw_base;
    if (raw_base < MIN_BASE_LOG2) c.base_log2 = MIN_BASE_LOG2;
    if (raw_base > MAX_BASE_LOG2) c.base_log2 = MAX_BASE_LOG2;
    c.classes = raw_cls;
    if (raw_cls < MIN_CLASSES) c.classes = MIN_CLASSES;
    if (raw_cls > MAX_CLASSES) c.classes = MAX_CLASSES;
    if ({1'b0, c.classes} > c.base_log2 + 4'd1) c.classes = 3'(c.base_log2 + 4'd1);
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] class_cap(logic [CLS_W-1:0] k, cfg_t c);
    logic [CNT_W-1:0] cap;
    cap = '0;
    if ({1'b0, k} < c.classes) begin
      cap = CNT_W'(1) << (c.base_log2 - 4'(k));
    end
    return cap;
  endfunction

endpackage

// ----- hdl/scsa_front.sv -----
`timescale 1ns / 1ps
// front end: classifies requests and holds them in a two-entry queue
// depends on scsa_pkg

module scsa_front (
  input  logic             clk,
  input  logic             rst_n,
  input  scsa_pkg::cfg_t   cfg,
  input  logic             in_push,
  output logic             in_full,
  input  scsa_pkg::in_item_t in_item,
  output logic             req_valid,
  output scsa_pkg::req_t   req,
  input  logic             req_pop
);

  scsa_pkg::req_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  scsa_pkg::req_t cls_req;
  logic [20:0] largest;
  logic [scsa_pkg::SIZE_W-1:0] idx;
  logic [4:0] blen;
  logic bad_size, bad_handle, push_ok;

  always_comb begin
    largest = 21'd1 << (6'(cfg.min_log2) + 6'(cfg.classes) - 6'd1);
    bad_size = (in_item.req_size == '0) || ({1'b0, in_item.req_size} > largest);
    idx = (in_item.req_size - scsa_pkg::SIZE_W'(1)) >> cfg.min_log2;
    blen = '0;
    for (int i = 0; i < scsa_pkg::SIZE_W; i++) begin
      if (idx[i]) blen = 5'(i + 1);
    end
    bad_handle = ({1'b0, in_item.free_class} >= cfg.classes) ||
                 ({1'b0, in_item.free_slot} >=
                  scsa_pkg::class_cap(in_item.free_class, cfg));
    cls_req.op = in_item.op;
    if (in_item.op == scsa_pkg::OP_ALLOC) begin
      cls_req.err  = bad_size ? scsa_pkg::ST_BAD_SIZE : scsa_pkg::ST_OK;
      cls_req.cls  = blen[scsa_pkg::CLS_W-1:0];
      cls_req.slot = '0;
    end else begin
      cls_req.err  = bad_handle ? scsa_pkg::ST_BAD_HANDLE : scsa_pkg::ST_OK;
      cls_req.cls  = in_item.free_class;
      cls_req.slot = in_item.free_slot;
    end
  end

  assign in_full   = (cnt_r == 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;

  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ req_pop;
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, req_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= cls_req;
  end

endmodule

// ----- hdl/scsa_back.sv -----
`timescale 1ns / 1ps
// back end: free lists, link and taken memories, two-step request execution
// depends on scsa_pkg

module scsa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  scsa_pkg::cfg_t     cfg,
  input  logic               rebuild,
  input  logic               req_valid,
  input  scsa_pkg::req_t     req,
  output logic               req_pop,
  input  logic               out_space,
  output logic               res_push,
  output scsa_pkg::out_item_t res
);

  localparam int NC = scsa_pkg::NUM_CLASSES;
  localparam int SW = scsa_pkg::SLOT_W;
  localparam int CW = scsa_pkg::CLS_W;
  localparam int NW = scsa_pkg::CNT_W;
  localparam int DEPTH = 1 << scsa_pkg::ADDR_W;

  scsa_pkg::bk_state_t state_r, state_nxt;

  logic [SW-1:0] head_r  [NC];
  logic [SW-1:0] head_nxt[NC];
  logic [NW-1:0] total_r  [NC];
  logic [NW-1:0] total_nxt[NC];
  logic [NW-1:0] fresh_r  [NC];
  logic [NW-1:0] fresh_nxt[NC];

  logic [SW-1:0] link_mem  [DEPTH];
  logic          taken_mem [DEPTH];
  logic [SW-1:0] link_q;
  logic          taken_q;

  scsa_pkg::req_t cur_r, cur_nxt;
  logic [CW-1:0] cls_r, cls_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          hit_r, hit_nxt;

  logic [CW-1:0] found;
  logic          hit;
  logic          rd_en;
  logic [scsa_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic          lk_we, tk_we, tk_wdata;
  logic [SW-1:0] lk_wdata;
  logic          fresh_pop, is_taken;

  // first non-empty class at or above the requested one
  always_comb begin
    found = req.cls;
    hit   = 1'b0;
    for (int k = 0; k < NC; k++) begin
      if (!hit && CW'(k) >= req.cls && (k < int'(cfg.classes)) &&
          total_r[k] != '0) begin
        hit   = 1'b1;
        found = CW'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cls_nxt   = cls_r;
    slot_nxt  = slot_r;
    hit_nxt   = hit_r;
    req_pop   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {found, head_r[found]};
    res_push  = 1'b0;
    res       = '0;
    lk_we     = 1'b0;
    tk_we     = 1'b0;
    lk_wdata  = '0;
    tk_wdata  = 1'b0;
    wr_addr   = {cls_r, slot_r};
    fresh_pop = 1'b0;
    is_taken  = 1'b0;
    for (int k = 0; k < NC; k++) begin
      head_nxt[k]  = head_r[k];
      total_nxt[k] = total_r[k];
      fresh_nxt[k] = fresh_r[k];
    end

    case (state_r)
      scsa_pkg::BK_IDLE: begin
        if (req_valid && out_space && !rebuild) begin
          req_pop = 1'b1;
          rd_en   = 1'b1;
          cur_nxt = req;
          hit_nxt = hit;
          if (req.op == scsa_pkg::OP_ALLOC) begin
            cls_nxt  = found;
            slot_nxt = head_r[found];
          end else begin
            cls_nxt  = req.cls;
            slot_nxt = req.slot;
          end
          rd_addr   = {cls_nxt, slot_nxt};
          state_nxt = scsa_pkg::BK_EXEC;
        end
      end
      scsa_pkg::BK_EXEC: begin
        res_push  = 1'b1;
        state_nxt = scsa_pkg::BK_IDLE;
        if (cur_r.err != scsa_pkg::ST_OK) begin
          res.status = cur_r.err;
        end else if (cur_r.op == scsa_pkg::OP_ALLOC) begin
          if (!hit_r) begin
            res.status = scsa_pkg::ST_EXHAUSTED;
          end else begin
            // slots at or past the fresh mark are still in rebuild order
            fresh_pop = ({1'b0, slot_r} >= fresh_r[cls_r]);
            head_nxt[cls_r]  = fresh_pop ? slot_r + SW'(1) : link_q;
            total_nxt[cls_r] = total_r[cls_r] - NW'(1);
            if (fresh_pop) fresh_nxt[cls_r] = fresh_r[cls_r] + NW'(1);
            tk_we    = 1'b1;
            tk_wdata = 1'b1;
            res.status      = scsa_pkg::ST_OK;
            res.grant_class = cls_r;
            res.grant_slot  = slot_r;
            res.free_left   = total_r[cls_r] - NW'(1);
          end
        end else begin
          is_taken = ({1'b0, slot_r} < fresh_r[cls_r]) && taken_q;
          if (!is_taken) begin
            res.status    = scsa_pkg::ST_DOUBLE_FREE;
            res.free_left = total_r[cls_r];
          end else begin
            tk_we    = 1'b1;
            tk_wdata = 1'b0;
            lk_we    = 1'b1;
            lk_wdata = head_r[cls_r];
            head_nxt[cls_r]  = slot_r;
            total_nxt[cls_r] = total_r[cls_r] + NW'(1);
            res.status      = scsa_pkg::ST_OK;
            res.grant_class = cls_r;
            res.free_left   = total_r[cls_r] + NW'(1);
          end
        end
      end
      default: state_nxt = scsa_pkg::BK_IDLE;
    endcase

    if (rebuild) begin
      for (int k = 0; k < NC; k++) begin
        head_nxt[k]  = '0;
        total_nxt[k] = scsa_pkg::class_cap(CW'(k), cfg);
        fresh_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scsa_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cls_r  <= cls_nxt;
    slot_r <= slot_nxt;
    hit_r  <= hit_nxt;
    for (int k = 0; k < NC; k++) begin
      head_r[k]  <= head_nxt[k];
      total_r[k] <= total_nxt[k];
      fresh_r[k] <= fresh_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_q  <= link_mem[rd_addr];
      taken_q <= taken_mem[rd_addr];
    end
    if (lk_we) link_mem[wr_addr] <= lk_wdata;
    if (tk_we) taken_mem[wr_addr] <= tk_wdata;
  end

endmodule

// ----- hdl/size_class_slot_allocator.sv -----
`timescale 1ns / 1ps
// top level of the size-class slot allocator: config registers, front, back,
// result queue; depends on scsa_pkg, scsa_front, scsa_back

// Power-of-two size-class slot allocator. Class k serves blocks of
// 2^(min_size_log2+k) bytes and owns 2^(base_count_log2-k) slots on a LIFO
// free list. An allocate request goes to the smallest fitting class, moving up
// to larger classes when it is empty; a free request is checked for a bad
// handle or a double free before its slot is pushed back. Each request gives
// exactly one result. The front end classifies requests into a two-entry
// queue; the back end handles one request at a time in two steps, reading
// the link and taken memories and then updating the lists, and takes the
// next request only when the last is done and the result queue has space. A
// config write (or reset) rebuilds every list in ascending order, with no
// clearing pass: a per-class fresh mark tells which slots have not been
// touched since the rebuild. Write config only while no request is in flight.

module size_class_slot_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_push,
  output logic                                in_full,
  input  scsa_pkg::in_item_t                  in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output scsa_pkg::out_item_t                 out_item
);

  // raw config registers
  logic [4:0] min_log2_r;
  logic [2:0] classes_r;
  logic [3:0] base_log2_r;
  logic       rebuild_r;
  scsa_pkg::cfg_t cfg;

  // front to back request
  logic           req_valid, req_pop;
  scsa_pkg::req_t req;

  // back to result queue
  logic                res_push, out_space;
  scsa_pkg::out_item_t res;

  // result queue
  scsa_pkg::out_item_t oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       opop_ok;

  assign cfg = scsa_pkg::eff_cfg(min_log2_r, classes_r, base_log2_r);

  // rebuild runs the cycle after reset or a register write, with new values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_log2_r  <= scsa_pkg::RST_MIN_LOG2;
      classes_r   <= scsa_pkg::RST_CLASSES;
      base_log2_r <= scsa_pkg::RST_BASE_LOG2;
      rebuild_r   <= 1'b1;
    end else begin
      rebuild_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          scsa_pkg::CFG_MIN_LOG2: begin
            min_log2_r <= cfg_data;
            rebuild_r  <= 1'b1;
          end
          scsa_pkg::CFG_CLASSES: begin
            classes_r <= cfg_data[2:0];
            rebuild_r <= 1'b1;
          end
          scsa_pkg::CFG_BASE_LOG2: begin
            base_log2_r <= cfg_data[3:0];
            rebuild_r   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  scsa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  scsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .rebuild   (rebuild_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_space (out_space),
    .res_push  (res_push),
    .res       (res)
  );

  // back only starts a request with a free result slot, so push never overflows
  assign out_space = (ocnt_r != 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign out_item  = oq_r[orp_r];
  assign opop_ok   = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_r ^ res_push;
      orp_r  <= orp_r ^ opop_ok;
      ocnt_r <= ocnt_r + {1'b0, res_push} - {1'b0, opop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oq_r[owp_r] <= res;
  end

endmodule

// ----- bench/size_class_slot_allocator_test.sv -----
`timescale 1ns / 1ps
// self-checking bench of the size-class slot allocator, with its own list model
// depends on scsa_pkg and size_class_slot_allocator

class slot_list_board;
  logic [4:0] raw_min;
  logic [2:0] raw_cls;
  logic [3:0] raw_base;
  logic [7:0] link [4][256];
  bit         taken [4][256];
  logic [7:0] head [4];
  int         total [4];
  scsa_pkg::out_item_t awaited [$];
  logic [9:0] live [$];   // {class, slot} of slots handed out
  int         errors;

  function new();
    errors = 0;
    raw_min = 5'd4;
    raw_cls = 3'd4;
    raw_base = 4'd8;
    rebuild();
  endfunction

  function int min_log2();
    return raw_min < 4 ? 4 : (raw_min > 16 ? 16 : raw_min);
  endfunction

  function int base_log2();
    return raw_base < 3 ? 3 : (raw_base > 8 ? 8 : raw_base);
  endfunction

  function int classes();
    int v;
    v = raw_cls < 2 ? 2 : (raw_cls > 4 ? 4 : raw_cls);
    if (v > base_log2() + 1) v = base_log2() + 1;
    return v;
  endfunction

  function int capacity(int k);
    return k >= classes() ? 0 : (1 << (base_log2() - k));
  endfunction

  function int largest();
    return 1 << (min_log2() + classes() - 1);
  endfunction

  function void rebuild();
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 256; i++) begin
        taken[k][i] = 0;
        link[k][i] = (i + 1 < capacity(k)) ? 8'(i + 1) : 8'd0;
      end
      head[k] = 0;
      total[k] = capacity(k);
    end
    live.delete();
  endfunction

  function void write_reg(logic [1:0] idx, logic [4:0] data);
    case (idx)
      scsa_pkg::CFG_MIN_LOG2: raw_min = data;
      scsa_pkg::CFG_CLASSES: raw_cls = data[2:0];
      scsa_pkg::CFG_BASE_LOG2: raw_base = data[3:0];
      default: return;
    endcase
    rebuild();
  endfunction

  // work out the result of one accepted request and queue it
  function void note_request(scsa_pkg::in_item_t it);
    scsa_pkg::out_item_t r;
    int cc, c, s, idx;
    r = '0;
    r.status = scsa_pkg::ST_OK;
    cc = classes();
    if (it.op == scsa_pkg::OP_ALLOC) begin
      if (it.req_size == 0 || it.req_size > largest()) begin
        r.status = scsa_pkg::ST_BAD_SIZE;
      end else begin
        idx = (it.req_size - 1) >> min_log2();
        c = 0;
        while (idx != 0) begin
          c++;
          idx >>= 1;
        end
        while (c < cc && total[c] == 0) c++;
        if (c >= cc) begin
          r.status = scsa_pkg::ST_EXHAUSTED;
        end else begin
          s = head[c];
          taken[c][s] = 1;
          head[c] = link[c][s];
          total[c]--;
          r.grant_class = 2'(c);
          r.grant_slot = 8'(s);
          r.free_left = 9'(total[c]);
          live.push_back({2'(c), 8'(s)});
        end
      end
    end else begin
      c = it.free_class;
      s = it.free_slot;
      if (c >= cc || s >= capacity(c)) begin
        r.status = scsa_pkg::ST_BAD_HANDLE;
      end else if (!taken[c][s]) begin
        r.status = scsa_pkg::ST_DOUBLE_FREE;
        r.free_left = 9'(total[c]);
      end else begin
        taken[c][s] = 0;
        link[c][s] = head[c];
        head[c] = 8'(s);
        total[c]++;
        r.grant_class = 2'(c);
        r.free_left = 9'(total[c]);
        foreach (live[i]) if (live[i] == {it.free_class, it.free_slot}) begin
          live.delete(i);
          break;
        end
      end
    end
    awaited.push_back(r);
  endfunction

  function void check_result(scsa_pkg::out_item_t got);
    scsa_pkg::out_item_t exp;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp = awaited.pop_front();
    if (got.status !== exp.status) begin
      $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      errors++;
    end
    if (got.grant_class !== exp.grant_class) begin
      $display("%0t: grant_class exp %0d got %0d", $time, exp.grant_class,
               got.grant_class);
      errors++;
    end
    if (got.grant_slot !== exp.grant_slot) begin
      $display("%0t: grant_slot exp %0d got %0d", $time, exp.grant_slot,
               got.grant_slot);
      errors++;
    end
    if (got.free_left !== exp.free_left) begin
      $display("%0t: free_left exp %0d got %0d", $time, exp.free_left,
               got.free_left);
      errors++;
    end
  endfunction
endclass

module size_class_slot_allocator_test;
  localparam int STALL_LIMIT = 5000;   // cycles with no request or result moving
  localparam int DRAIN_WAIT  = 10;     // extra wait after the last awaited result
  localparam int IN_W        = $bits(scsa_pkg::in_item_t);

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [scsa_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [scsa_pkg::CFG_DATA_W-1:0] cfg_data;
  logic      in_push;
  logic      in_full;
  scsa_pkg::in_item_t  in_item;
  logic      out_empty;
  logic      out_pop = 1'b0;
  scsa_pkg::out_item_t out_item;

  slot_list_board board;
  bit  no_idle;       // long stretch with both sides always ready
  bit  running;
  int  quiet_cycles = 0;

  size_class_slot_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: check at each edge with the values held before it, then
  // pick the next pop; the same block watches for a hung block
  always @(posedge clk) begin
    if (running) begin
      if (out_pop && !out_empty) board.check_result(out_item);
      if ((out_pop && !out_empty) || (in_push && !in_full)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
    out_pop <= no_idle || ($urandom_range(99) >= 23);
  end

  // hand one request over, idling at random before it
  task automatic send_request(scsa_pkg::in_item_t it);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    board.note_request(it);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // all three registers, block must be idle
  task automatic configure(logic [4:0] m, logic [4:0] c, logic [4:0] b);
    drain();
    write_reg(scsa_pkg::CFG_MIN_LOG2, m);
    write_reg(scsa_pkg::CFG_CLASSES, c);
    write_reg(scsa_pkg::CFG_BASE_LOG2, b);
    @(posedge clk);
  endtask

  task automatic alloc_req(int size);
    scsa_pkg::in_item_t it;
    it = IN_W'($urandom);
    it.op = scsa_pkg::OP_ALLOC;
    it.req_size = scsa_pkg::SIZE_W'(size);
    send_request(it);
  endtask

  task automatic free_req(int cls, int slot);
    scsa_pkg::in_item_t it;
    it = IN_W'($urandom);
    it.op = scsa_pkg::OP_FREE;
    it.free_class = 2'(cls);
    it.free_slot = 8'(slot);
    send_request(it);
  endtask

  // mostly sizes that fit, sometimes edges and raw 20-bit noise
  function automatic int pick_size();
    int top, k;
    top = board.largest();
    k = $urandom_range(99);
    if (k < 3) return 0;
    if (k < 6) return top;
    if (k < 9) return top + 1;
    if (k < 13) return $urandom_range(20'hFFFFF);
    return $urandom_range(top, 1);
  endfunction

  // random phase: allocations and frees of live slots, plus frees of random handles
  task automatic random_phase(int n);
    int k, pick;
    logic [9:0] h;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        alloc_req(pick_size());
      end else if (k < 88 && board.live.size() != 0) begin
        pick = $urandom_range(board.live.size() - 1);
        h = board.live[pick];
        free_req(h[9:8], h[7:0]);
      end else if (k < 94) begin
        // likely a double free of a small slot
        free_req($urandom_range(3), $urandom_range(7));
      end else begin
        free_req($urandom_range(3), $urandom_range(255));
      end
    end
  endtask

  initial begin
    board = new();
    running = 0;
    no_idle = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    in_push = 0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    running = 1;
    @(posedge clk);

    // directed, reset config: 16..128 byte classes, 256/128/64/32 slots
    alloc_req(0);
    alloc_req(1);
    alloc_req(16);
    alloc_req(17);
    alloc_req(128);
    alloc_req(129);
    alloc_req(20'hFFFFF);
    free_req(1, 255);          // beyond class capacity
    free_req(0, 200);          // never taken
    free_req(0, 0);            // good free
    free_req(0, 0);            // same slot again
    free_req(3, 31);           // last slot of the top class, not taken
    alloc_req(64);
    free_req(2, 0);

    // smallest lists, then exhaust the top class
    configure(5'd16, 5'd2, 5'd3);
    for (int i = 0; i < 14; i++) alloc_req(1 << 17);
    free_req(2, 0);            // class not in use
    free_req(1, 3);
    free_req(1, 4);            // bad slot for a four-slot class
    random_phase(150);

    configure(5'd4, 5'd4, 5'd3);
    random_phase(200);

    // out of range values saturate
    configure(5'd0, 5'd7, 5'd15);
    random_phase(200);
    configure(5'd31, 5'd0, 5'd1);
    random_phase(200);

    // unused register index: nothing is rebuilt
    drain();
    write_reg(2'd3, 5'd9);
    no_idle = 1;
    random_phase(200);
    no_idle = 0;

    configure(5'd10, 5'd3, 5'd5);
    random_phase(200);
    for (int p = 0; p < 3; p++) begin
      configure(5'($urandom_range(31)), 5'($urandom_range(7)),
                5'($urandom_range(15)));
      random_phase(150);
    end

    drain();
    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/scsa_pkg.sv
hdl/scsa_front.sv
hdl/scsa_back.sv
hdl/size_class_slot_allocator.sv
bench/size_class_slot_allocator_test.sv
